// ----- design/wbpm_pkg.sv -----
// ----------------------------------------------------------------------------
// wbpm_pkg
// Shared types and constants for the wildcard byte pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wbpm_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK  = 2'd3;

  // register field widths
  localparam int LEN_W       = 5;
  localparam int PAT_BYTES   = 16;
  localparam int PAT_IDX_W   = 4;
  localparam int MASK_W      = 16;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

  // data handed from one cell to the next
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
  } link_t;

  // per-cell compare setup, aligned to the cell position
  typedef struct packed {
    logic       used;
    logic       wild;
    logic [7:0] pat;
  } cell_cfg_t;

endpackage

`default_nettype wire

// ----- design/wildcard_byte_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_matcher
// Streams a buffer byte by byte and reports every start offset at which the
// configured pattern (with per-byte wildcards) matches.
// ----------------------------------------------------------------------------
// Usage: bytes of a buffer arrive on the s_axis channel, s_axis_tlast on the
// final byte. A record leaves on m_axis for every byte at which a match ends
// (match_found set, match_offset = start of the match) and for the final byte
// (m_axis_tlast set), both in one record when they coincide.
// A record is registered and appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle unless stalled; the row of window cells shifts on every
// transaction and all pattern positions compare in parallel in that cycle.
// Receiver stall: a record waits in the output register; a new byte is still
// taken in the cycle the held record is taken, otherwise s_axis_tready drops.
// Reset: window valid bits and the byte count clear, pattern_length returns
// to 1 and the pattern and wildcard registers to zero. The final byte of a
// buffer clears the window and count the same way for the next buffer.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_matcher #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int OFFSET_WIDTH      = 31
) (
  input  wire                                      clk,
  input  wire                                      rst,
  // configuration
  input  wire                                      cfg_we,
  input  wire  [wbpm_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  wire  [wbpm_pkg::CFG_DATA_W-1:0]          cfg_data,
  // byte stream in
  input  wire                                      s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire  [7:0]                               s_axis_tdata,  // data_byte
  input  wire                                      s_axis_tlast,
  // result records out
  output logic                                     m_axis_tvalid,
  input  wire                                      m_axis_tready,
  // [0] match_found, [OFFSET_WIDTH:1] match_offset, rest zero
  output logic [((OFFSET_WIDTH+1+7)/8)*8-1:0]      m_axis_tdata,
  output logic                                     m_axis_tlast
);

  import wbpm_pkg::*;

  localparam int TDATA_W = ((OFFSET_WIDTH + 1 + 7) / 8) * 8;
  localparam int REC_W   = OFFSET_WIDTH + 2;
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

  // configuration registers
  logic [LEN_W-1:0]       pattern_length;
  logic [CFG_DATA_W-1:0]  pattern_bytes_low;
  logic [CFG_DATA_W-1:0]  pattern_bytes_high;
  logic [MASK_W-1:0]      wildcard_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= LEN_RESET;
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
      wildcard_mask      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length     <= cfg_data[LEN_W-1:0];
        REG_PATTERN_LOW:    pattern_bytes_low  <= cfg_data;
        REG_PATTERN_HIGH:   pattern_bytes_high <= cfg_data;
        REG_WILDCARD_MASK:  wildcard_mask      <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  logic [8*PAT_BYTES-1:0] pattern_all;
  assign pattern_all = {pattern_bytes_high, pattern_bytes_low};

  // handshake
  logic accept;
  logic room;
  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // row of window cells, cell 0 holds the newest byte
  link_t                        links [MAX_PATTERN_BYTES+1];
  cell_cfg_t                    cell_cfg [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hits;

  assign links[0].data  = s_axis_tdata;
  assign links[0].valid = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [LEN_W-1:0]     rel;
    logic [PAT_IDX_W-1:0] pidx;

    // cell k lines up with pattern byte (length - 1 - k)
    assign rel  = pattern_length - LEN_W'(k + 1);
    assign pidx = rel[PAT_IDX_W-1:0];

    assign cell_cfg[k].used = LEN_W'(k) < pattern_length;
    assign cell_cfg[k].wild = wildcard_mask[pidx];
    assign cell_cfg[k].pat  = pattern_all[{pidx, 3'b000} +: 8];

    wbpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (accept),
      .clear    (s_axis_tlast),
      .link_in  (links[k]),
      .cfg      (cell_cfg[k]),
      .link_out (links[k+1]),
      .hit      (hits[k])
    );
  end

  // running byte count of the current buffer, saturating
  logic [OFFSET_WIDTH-1:0] bytes_seen;
  logic [OFFSET_WIDTH-1:0] bytes_seen_next;

  always_comb begin
    bytes_seen_next = bytes_seen;
    if (accept) begin
      if (s_axis_tlast) begin
        bytes_seen_next = '0;
      end else if (bytes_seen != OFFSET_MAX) begin
        bytes_seen_next = bytes_seen + OFFSET_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else begin
      bytes_seen <= bytes_seen_next;
    end
  end

  // match decision and record build
  logic                    len_ok;
  logic                    found;
  logic [OFFSET_WIDTH-1:0] offset;
  logic [REC_W-1:0]        rec;
  logic [REC_W-1:0]        rec_out;

  assign len_ok = (pattern_length != '0) &&
                  (pattern_length <= LEN_W'(MAX_PATTERN_BYTES));
  assign found  = len_ok && (&hits);

  always_comb begin
    offset = '0;
    if (found) begin
      if (bytes_seen == OFFSET_MAX) begin
        offset = OFFSET_MAX;
      end else begin
        offset = bytes_seen - OFFSET_WIDTH'(pattern_length - LEN_W'(1));
      end
    end
  end

  assign rec = {s_axis_tlast, offset, found};

  wbpm_out_stage #(
    .DATA_W (REC_W)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && (found || s_axis_tlast)),
    .load_data (rec),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (rec_out)
  );

  assign m_axis_tdata = TDATA_W'(rec_out[REC_W-2:0]);
  assign m_axis_tlast = rec_out[REC_W-1];

  // checks
  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> bytes_seen == '0)
    else $error("byte count not cleared after final byte");

  a_last_reported: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("final byte gave no end-of-buffer record");

  a_record_has_cause: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> rec_out[0] || m_axis_tlast)
    else $error("record with neither match nor end of buffer");

  a_no_match_zero_offset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !rec_out[0] |-> rec_out[REC_W-2:1] == '0)
    else $error("offset set on a record without a match");

  a_bad_length_no_match: assert property (@(posedge clk) disable iff (rst)
    !len_ok |-> !found)
    else $error("match reported with unusable pattern length");

endmodule

`default_nettype wire

// ----- design/wbpm_cell.sv -----
// ----------------------------------------------------------------------------
// wbpm_cell
// One window position: holds a byte and its valid bit, compares the byte
// about to be latched against its pattern byte, passes its byte onward.
// ----------------------------------------------------------------------------
`default_nettype none

module wbpm_cell (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    shift,
  input  wire                    clear,
  input  wbpm_pkg::link_t        link_in,
  input  wbpm_pkg::cell_cfg_t    cfg,
  output wbpm_pkg::link_t        link_out,
  output logic                   hit
);

  import wbpm_pkg::*;

  logic [7:0] data;
  logic       valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= clear ? 1'b0 : link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= link_in.data;
    end
  end

  // unused positions always agree; used ones need a byte of this buffer
  assign hit = !cfg.used || (link_in.valid && (cfg.wild || link_in.data == cfg.pat));

  assign link_out.data  = data;
  assign link_out.valid = valid;

endmodule

`default_nettype wire

// ----- design/wbpm_out_stage.sv -----
// ----------------------------------------------------------------------------
// wbpm_out_stage
// Output register for result records; frees the input side whenever the
// held record is taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wbpm_out_stage #(
  parameter int DATA_W = 33
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               load,
  input  wire  [DATA_W-1:0] load_data,
  output logic              room,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [DATA_W-1:0] out_data
);

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard byte pattern matcher. Byte buffers
// are streamed in under random idling and a long receiver stall, an
// in-bench model of the shift window predicts every match and end-of-buffer
// record, and each record leaving the block is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  import wbpm_pkg::*;

  localparam int OFFSET_W = 31;
  localparam int TDATA_W  = ((OFFSET_W + 1 + 7) / 8) * 8;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
    logic                eob;
  } record_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata;   // data_byte
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_W-1:0]     m_axis_tdata;   // [0] match_found, [31:1] match_offset
  logic                   m_axis_tlast;

  // shadow of the configuration registers
  logic [LEN_W-1:0]  shadow_len = LEN_RESET;
  logic [63:0]       shadow_low = '0;
  logic [63:0]       shadow_high = '0;
  logic [MASK_W-1:0] shadow_mask = '0;

  // predicted window and byte count
  logic [7:0]          window_bytes [PAT_BYTES];
  logic [OFFSET_W-1:0] bytes_seen = '0;

  record_t pending_records [$];
  int      error_count = 0;
  int      hold_request = 0;
  bit      send_no_idle = 1'b0;
  bit      recv_no_idle = 1'b0;

  wildcard_byte_pattern_matcher #(
    .MAX_PATTERN_BYTES(PAT_BYTES),
    .OFFSET_WIDTH     (OFFSET_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    for (int k = 0; k < PAT_BYTES; k++) window_bytes[k] = 8'h00;
  end

  function automatic logic [7:0] pattern_byte(input int idx);
    logic [127:0] pat;
    pat = {shadow_high, shadow_low};
    return pat[8*idx +: 8];
  endfunction

  function automatic logic [7:0] narrow_byte();
    case ($urandom_range(0, 2))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'h5A;
    endcase
  endfunction

  // shift the byte in, compare against the pattern, queue the record it causes
  function automatic void predict_record(input logic [7:0] data, input logic last);
    record_t             rec;
    logic [OFFSET_W-1:0] position;
    int                  n;
    int                  i;
    bit                  hit;
    position = bytes_seen;
    for (i = PAT_BYTES - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
    window_bytes[0] = data;
    if (bytes_seen != OFFSET_MAX) bytes_seen = bytes_seen + 1'b1;
    n = int'(shadow_len);
    hit = (n >= 1) && (n <= PAT_BYTES) && (bytes_seen >= n);
    if (hit) begin
      for (i = 0; i < n; i++) begin
        if (!shadow_mask[i] && window_bytes[n-1-i] != pattern_byte(i)) hit = 1'b0;
      end
    end
    rec.found  = hit;
    rec.offset = '0;
    if (hit) rec.offset = (position == OFFSET_MAX) ? OFFSET_MAX : position - OFFSET_W'(n - 1);
    rec.eob = last;
    if (last) begin
      for (i = 0; i < PAT_BYTES; i++) window_bytes[i] = 8'h00;
      bytes_seen = '0;
    end
    if (hit || last) pending_records.insert(pending_records.size(), rec);
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = send_no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    predict_record(data, last);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    // a byte with no record may still sit in the pipeline
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LENGTH: shadow_len  = value[LEN_W-1:0];
      REG_PATTERN_LOW:    shadow_low  = value;
      REG_PATTERN_HIGH:   shadow_high = value;
      REG_WILDCARD_MASK:  shadow_mask = value[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [LEN_W-1:0] len, input logic [63:0] low,
                           input logic [63:0] high, input logic [MASK_W-1:0] mask);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_PATTERN_LOW, low);
    write_reg(REG_PATTERN_HIGH, high);
    write_reg(REG_WILDCARD_MASK, CFG_DATA_W'(mask));
    cfg_we <= 1'b0;
  endtask

  // reset pattern is one zero byte
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // middle byte wild, mask bits past the length must not matter
  task automatic test_overlap_wildcards();
    configure(5'd3, 64'h0000_0000_00AB_00AB, 64'h0, 16'hFFF2);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'hAB, 1'b1);
  endtask

  task automatic test_short_buffer();
    send_byte(8'hAB, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // only first and last pattern bytes compared
  task automatic test_full_length();
    int i;
    configure(5'd16, 64'h0123_4567_89AB_CDFF, 64'h00FE_DCBA_9876_5432, 16'h7FFE);
    send_byte(8'hFF, 1'b0);
    for (i = 0; i < 14; i++) send_byte(8'($urandom), 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_invalid_length();
    configure(5'd0, 64'h0, 64'h0, 16'hFFFF);
    send_byte(8'h00, 1'b1);
    configure(5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_byte(8'hFF, 1'b1);
  endtask

  // count restarts per buffer, so a match never spans two buffers
  task automatic test_buffer_boundary();
    configure(5'd2, 64'h0, 64'h0, 16'h0000);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // every byte matches; the sink holds off long enough to back up the input
  task automatic test_backpressure();
    int i;
    configure(5'd1, 64'h0, 64'h0, 16'h0001);
    send_no_idle = 1'b1;
    recv_no_idle = 1'b1;
    hold_request = 80;
    for (i = 0; i < 60; i++) send_byte(8'($urandom), i == 59);
    send_no_idle = 1'b0;
    recv_no_idle = 1'b0;
  endtask

  task automatic test_random_buffers(input int item_target);
    int               sent;
    int               phase_end;
    int               buf_len;
    int               ins_pos;
    int               n;
    int               i;
    int               r;
    bit               narrow;
    logic [7:0]       value;
    logic [LEN_W-1:0] len;
    logic [63:0]      low;
    logic [63:0]      high;
    logic [MASK_W-1:0] mask;
    sent = 0;
    while (sent < item_target) begin
      r = $urandom_range(0, 19);
      if (r == 0) len = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
      else if (r < 4) len = 5'd16;
      else if (r < 7) len = 5'd1;
      else len = 5'($urandom_range(2, 15));
      narrow = ($urandom_range(0, 1) == 0);
      if (narrow) begin
        for (i = 0; i < 8; i++) begin
          low[8*i +: 8]  = narrow_byte();
          high[8*i +: 8] = narrow_byte();
        end
      end else begin
        low  = {$urandom, $urandom};
        high = {$urandom, $urandom};
      end
      r = $urandom_range(0, 7);
      if (r < 3) mask = '0;
      else if (r < 5) mask = 16'($urandom & $urandom & $urandom);
      else if (r < 7) mask = 16'($urandom);
      else mask = 16'hFFFF;
      configure(len, low, high, mask);
      send_no_idle = ($urandom_range(0, 3) == 0);
      recv_no_idle = ($urandom_range(0, 3) == 0);
      n = int'(len);
      phase_end = sent + $urandom_range(60, 140);
      while (sent < phase_end && sent < item_target) begin
        buf_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 48);
        ins_pos = -1;
        for (i = 0; i < buf_len; i++) begin
          // mostly plant the pattern, with an occasional broken byte
          if (ins_pos < 0 && n >= 1 && n <= PAT_BYTES && $urandom_range(0, 3) == 0)
            ins_pos = 0;
          if (ins_pos >= 0) begin
            value = pattern_byte(ins_pos);
            if (mask[ins_pos] || $urandom_range(0, 15) == 0) value = 8'($urandom);
            ins_pos++;
            if (ins_pos >= n) ins_pos = -1;
          end else if ($urandom_range(0, 3) == 0) begin
            value = 8'($urandom);
          end else if (narrow) begin
            value = narrow_byte();
          end else begin
            value = pattern_byte($urandom_range(0, PAT_BYTES - 1));
          end
          send_byte(value, i == buf_len - 1);
          sent++;
        end
      end
    end
    send_no_idle = 1'b0;
    recv_no_idle = 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = recv_no_idle ? 0 : $urandom_range(0, 4);
      if (hold_request > 0) begin
        gap = hold_request;
        hold_request = 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
    end
  end

  always @(posedge clk) begin : record_checker
    record_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (pending_records.size() == 0) begin
        $error("unexpected transaction: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = pending_records.pop_front();
        if (m_axis_tdata[0] !== want.found) begin
          $error("match_found expected %0d actual %0d", want.found, m_axis_tdata[0]);
          error_count++;
        end
        if (m_axis_tdata[OFFSET_W:1] !== want.offset) begin
          $error("match_offset expected %0d actual %0d", want.offset, m_axis_tdata[OFFSET_W:1]);
          error_count++;
        end
        if (m_axis_tlast !== want.eob) begin
          $error("end_of_buffer expected %0d actual %0d", want.eob, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  initial begin : test_sequence
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_PATTERN_LENGTH;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_overlap_wildcards();
    test_short_buffer();
    test_full_length();
    test_invalid_length();
    test_buffer_boundary();
    test_backpressure();
    test_random_buffers(850);

    wait_idle();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
